// ===== src/fixed_point_q24_8_alu_defines.svh =====
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH

// Same-cycle implication check
`define FPA_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpa check failed");

// Next-cycle implication check
`define FPA_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpa check failed");

`endif

// ===== src/fpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NA_W      = DATA_W + FRAC_BITS;
    localparam int DIV_STEPS = NA_W;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int QR_W      = NA_W + 1;

    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [QR_W-1:0]   qr_t;

    localparam logic [DATA_W-1:0] MAX_VAL  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_VAL  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam prod_t             MUL_HALF = prod_t'(1) << (FRAC_BITS - 1);

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_INC      = 4'd4,
        CMD_DEC      = 4'd5,
        CMD_MIN      = 4'd6,
        CMD_MAX      = 4'd7,
        CMD_TO_INT   = 4'd8,
        CMD_FROM_INT = 4'd9
    } cmd_e;

    // Everything an item carries alongside the divider data
    typedef struct packed {
        logic              is_div;
        logic              neg;
        logic              ov;
        logic              dz;
        logic              gt;
        logic              lt;
        logic              eq;
        logic [DATA_W-1:0] res;
    } side_t;

    typedef struct packed {
        logic              ov;
        logic [DATA_W-1:0] val;
    } sat_t;

    // Apply sign to a magnitude and saturate to the signed 32-bit range
    function automatic sat_t sat_mag(input prod_t mag, input logic neg);
        sat_t s;
        s.ov  = 1'b0;
        s.val = neg ? (-mag[DATA_W-1:0]) : mag[DATA_W-1:0];
        if (neg)
        begin
            if (mag > prod_t'(MIN_VAL))
            begin
                s.ov  = 1'b1;
                s.val = MIN_VAL;
            end
        end
        else if (mag > prod_t'(MAX_VAL))
        begin
            s.ov  = 1'b1;
            s.val = MAX_VAL;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/fpa_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fpa_prep (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [3:0]                     command,
    input  wire logic [fpa_pkg::DATA_W-1:0]     operand_a,
    input  wire logic [fpa_pkg::DATA_W-1:0]     operand_b,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output fpa_pkg::side_t                      out_side,
    output logic [fpa_pkg::NA_W-1:0]            out_na,
    output logic [fpa_pkg::DATA_W-1:0]          out_nb
);

    logic                          v1_reg, v2_reg, v3_reg;
    logic                          rdy1, rdy2, rdy3;

    logic [3:0]                    cmd1_reg;
    logic [fpa_pkg::DATA_W-1:0]    a1_reg, b1_reg;

    fpa_pkg::side_t                side2_reg, side2_next;
    logic                          mul2_reg;
    fpa_pkg::prod_t                prod2_reg, prod2_next;
    logic [fpa_pkg::NA_W-1:0]      na2_reg, na3_reg;
    logic [fpa_pkg::DATA_W-1:0]    nb2_reg, nb3_reg;
    fpa_pkg::side_t                side3_reg, side3_next;

    logic [fpa_pkg::DATA_W-1:0]    mag_a, mag_b;
    logic [fpa_pkg::DATA_W:0]      sum_w, dif_w, inc_w, dec_w;
    logic [fpa_pkg::DATA_W-1:0]    shr_a;
    fpa_pkg::prod_t                mul_rnd;
    fpa_pkg::sat_t                 mul_sat;

    function automatic fpa_pkg::sat_t clamp_wide(input logic [fpa_pkg::DATA_W:0] v);
        fpa_pkg::sat_t s;
        s.ov  = v[fpa_pkg::DATA_W] ^ v[fpa_pkg::DATA_W-1];
        s.val = v[fpa_pkg::DATA_W-1:0];
        if (s.ov)
        begin
            s.val = v[fpa_pkg::DATA_W] ? fpa_pkg::MIN_VAL : fpa_pkg::MAX_VAL;
        end
        return s;
    endfunction

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 2: flags, simple results, magnitudes and the raw product
    always_comb
    begin
        fpa_pkg::sat_t s;
        mag_a = a1_reg[fpa_pkg::DATA_W-1] ? (-a1_reg) : a1_reg;
        mag_b = b1_reg[fpa_pkg::DATA_W-1] ? (-b1_reg) : b1_reg;
        sum_w = {a1_reg[fpa_pkg::DATA_W-1], a1_reg} + {b1_reg[fpa_pkg::DATA_W-1], b1_reg};
        dif_w = {a1_reg[fpa_pkg::DATA_W-1], a1_reg} - {b1_reg[fpa_pkg::DATA_W-1], b1_reg};
        inc_w = {a1_reg[fpa_pkg::DATA_W-1], a1_reg} + (fpa_pkg::DATA_W+1)'(1);
        dec_w = {a1_reg[fpa_pkg::DATA_W-1], a1_reg} - (fpa_pkg::DATA_W+1)'(1);
        shr_a = $unsigned($signed(a1_reg) >>> fpa_pkg::FRAC_BITS);

        prod2_next = fpa_pkg::prod_t'(mag_a) * fpa_pkg::prod_t'(mag_b);

        side2_next        = '0;
        side2_next.neg    = a1_reg[fpa_pkg::DATA_W-1] ^ b1_reg[fpa_pkg::DATA_W-1];
        side2_next.gt     = $signed(a1_reg) > $signed(b1_reg);
        side2_next.lt     = $signed(a1_reg) < $signed(b1_reg);
        side2_next.eq     = a1_reg == b1_reg;
        s                 = '0;

        case (cmd1_reg)
            fpa_pkg::CMD_ADD: s = clamp_wide(sum_w);
            fpa_pkg::CMD_SUB: s = clamp_wide(dif_w);
            fpa_pkg::CMD_INC: s = clamp_wide(inc_w);
            fpa_pkg::CMD_DEC: s = clamp_wide(dec_w);
            fpa_pkg::CMD_MIN: s.val = side2_next.gt ? b1_reg : a1_reg;
            fpa_pkg::CMD_MAX: s.val = side2_next.lt ? b1_reg : a1_reg;
            fpa_pkg::CMD_TO_INT:
            begin
                // truncate toward zero
                s.val = shr_a;
                if (a1_reg[fpa_pkg::DATA_W-1] && (|a1_reg[fpa_pkg::FRAC_BITS-1:0]))
                begin
                    s.val = shr_a + fpa_pkg::DATA_W'(1);
                end
            end
            fpa_pkg::CMD_FROM_INT:
            begin
                s.val = a1_reg << fpa_pkg::FRAC_BITS;
                if (!((&a1_reg[fpa_pkg::DATA_W-1 -: fpa_pkg::FRAC_BITS+1])
                      || !(|a1_reg[fpa_pkg::DATA_W-1 -: fpa_pkg::FRAC_BITS+1])))
                begin
                    s.ov  = 1'b1;
                    s.val = a1_reg[fpa_pkg::DATA_W-1] ? fpa_pkg::MIN_VAL : fpa_pkg::MAX_VAL;
                end
            end
            fpa_pkg::CMD_DIV:
            begin
                if (b1_reg == '0)
                begin
                    side2_next.dz = 1'b1;
                    if (a1_reg[fpa_pkg::DATA_W-1])
                    begin
                        s.ov  = 1'b1;
                        s.val = fpa_pkg::MIN_VAL;
                    end
                    else if (a1_reg != '0)
                    begin
                        s.ov  = 1'b1;
                        s.val = fpa_pkg::MAX_VAL;
                    end
                end
                else
                begin
                    side2_next.is_div = 1'b1;
                end
            end
            default: s = '0;
        endcase

        side2_next.ov  = s.ov;
        side2_next.res = s.val;
    end

    // Stage 3: round and saturate the product
    always_comb
    begin
        mul_rnd    = (prod2_reg + fpa_pkg::MUL_HALF) >> fpa_pkg::FRAC_BITS;
        mul_sat    = fpa_pkg::sat_mag(mul_rnd, side2_reg.neg);
        side3_next = side2_reg;
        if (mul2_reg)
        begin
            side3_next.ov  = mul_sat.ov;
            side3_next.res = mul_sat.val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            cmd1_reg <= command;
            a1_reg   <= operand_a;
            b1_reg   <= operand_b;
        end
        if (rdy2 && v1_reg)
        begin
            side2_reg <= side2_next;
            mul2_reg  <= cmd1_reg == fpa_pkg::CMD_MUL;
            prod2_reg <= prod2_next;
            na2_reg   <= {mag_a, {fpa_pkg::FRAC_BITS{1'b0}}};
            nb2_reg   <= mag_b;
        end
        if (rdy3 && v2_reg)
        begin
            side3_reg <= side3_next;
            na3_reg   <= na2_reg;
            nb3_reg   <= nb2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign out_na    = na3_reg;
    assign out_nb    = nb3_reg;

endmodule

`default_nettype wire

// ===== src/fpa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage
module fpa_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire fpa_pkg::side_t                 in_side,
    input  wire logic [fpa_pkg::NA_W-1:0]       in_na,
    input  wire logic [fpa_pkg::DATA_W-1:0]     in_nb,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output fpa_pkg::side_t                      out_side,
    output logic [fpa_pkg::NA_W-1:0]            out_quo,
    output logic [fpa_pkg::DATA_W-1:0]          out_rem,
    output logic [fpa_pkg::DATA_W-1:0]          out_nb
);

    logic                          v_reg    [fpa_pkg::DIV_STEPS];
    fpa_pkg::side_t                side_reg [fpa_pkg::DIV_STEPS];
    logic [fpa_pkg::NA_W-1:0]      na_reg   [fpa_pkg::DIV_STEPS];
    logic [fpa_pkg::NA_W-1:0]      quo_reg  [fpa_pkg::DIV_STEPS];
    logic [fpa_pkg::DATA_W-1:0]    rem_reg  [fpa_pkg::DIV_STEPS];
    logic [fpa_pkg::DATA_W-1:0]    nb_reg   [fpa_pkg::DIV_STEPS];
    logic [fpa_pkg::DIV_STEPS:0]   rdy;

    assign rdy[fpa_pkg::DIV_STEPS] = out_ready;
    assign in_ready                = rdy[0];

    for (genvar i = 0; i < fpa_pkg::DIV_STEPS; i++)
    begin : g_stage
        logic                        src_v;
        fpa_pkg::side_t              src_side;
        logic [fpa_pkg::NA_W-1:0]    src_na, src_quo, na_next, quo_next;
        logic [fpa_pkg::DATA_W-1:0]  src_rem, src_nb, rem_next;
        logic [fpa_pkg::DATA_W:0]    trial;
        logic                        take;

        if (i == 0)
        begin : g_first
            assign src_v    = in_valid;
            assign src_side = in_side;
            assign src_na   = in_na;
            assign src_quo  = '0;
            assign src_rem  = '0;
            assign src_nb   = in_nb;
        end
        else
        begin : g_rest
            assign src_v    = v_reg[i-1];
            assign src_side = side_reg[i-1];
            assign src_na   = na_reg[i-1];
            assign src_quo  = quo_reg[i-1];
            assign src_rem  = rem_reg[i-1];
            assign src_nb   = nb_reg[i-1];
        end

        assign rdy[i] = !v_reg[i] || rdy[i+1];

        always_comb
        begin
            trial    = {src_rem, src_na[fpa_pkg::NA_W-1]};
            take     = trial >= {1'b0, src_nb};
            rem_next = take ? (trial[fpa_pkg::DATA_W-1:0] - src_nb)
                            : trial[fpa_pkg::DATA_W-1:0];
            na_next  = src_na << 1;
            quo_next = {src_quo[fpa_pkg::NA_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (rdy[i])
            begin
                v_reg[i] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i] && src_v)
            begin
                side_reg[i] <= src_side;
                na_reg[i]   <= na_next;
                quo_reg[i]  <= quo_next;
                rem_reg[i]  <= rem_next;
                nb_reg[i]   <= src_nb;
            end
        end
    end

    assign out_valid = v_reg[fpa_pkg::DIV_STEPS-1];
    assign out_side  = side_reg[fpa_pkg::DIV_STEPS-1];
    assign out_quo   = quo_reg[fpa_pkg::DIV_STEPS-1];
    assign out_rem   = rem_reg[fpa_pkg::DIV_STEPS-1];
    assign out_nb    = nb_reg[fpa_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== src/fixed_point_q24_8_alu.sv =====
// channel | valid     | stall      | payload
// --------+-----------+------------+--------------------------------------------
// in      | in_valid  | in_stall   | command, operand_a, operand_b
// out     | out_valid | out_stall  | result, a_greater, a_less, a_equal,
//         |           |            | overflow, div_by_zero
//
// One item per cycle sustained while out_stall is low; every command passes through
// 3 prep stages (input capture, decode and 32x32 multiply, product rounding),
// 40 divider stages (one quotient bit each) and the output register.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage moves when it is empty or the next one moves, so bubbles
// close up under out_stall and nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_q24_8_alu_defines.svh"

module fixed_point_q24_8_alu (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [3:0]                     command,
    input  wire logic [fpa_pkg::DATA_W-1:0]     operand_a,
    input  wire logic [fpa_pkg::DATA_W-1:0]     operand_b,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [fpa_pkg::DATA_W-1:0]          result,
    output logic                                a_greater,
    output logic                                a_less,
    output logic                                a_equal,
    output logic                                overflow,
    output logic                                div_by_zero
);

    logic                          prep_ready, prep_valid;
    fpa_pkg::side_t                prep_side;
    logic [fpa_pkg::NA_W-1:0]      prep_na;
    logic [fpa_pkg::DATA_W-1:0]    prep_nb;

    logic                          div_valid, div_ready;
    fpa_pkg::side_t                div_side;
    logic [fpa_pkg::NA_W-1:0]      div_quo;
    logic [fpa_pkg::DATA_W-1:0]    div_rem, div_nb;

    logic                          out_valid_reg;
    logic [fpa_pkg::DATA_W-1:0]    result_reg, result_next;
    logic                          gt_reg, lt_reg, eq_reg, ov_reg, ov_next, dz_reg;
    logic                          round_up;
    fpa_pkg::qr_t                  qr;
    fpa_pkg::sat_t                 div_sat;
    logic [2:0]                    cmp_flags;
    logic                          fin_ready;

    fpa_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (prep_ready),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (prep_valid),
        .out_ready (div_ready),
        .out_side  (prep_side),
        .out_na    (prep_na),
        .out_nb    (prep_nb)
    );

    logic div_in_ready;
    assign div_ready = div_in_ready;

    fpa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (div_in_ready),
        .in_side   (prep_side),
        .in_na     (prep_na),
        .in_nb     (prep_nb),
        .out_valid (div_valid),
        .out_ready (fin_ready),
        .out_side  (div_side),
        .out_quo   (div_quo),
        .out_rem   (div_rem),
        .out_nb    (div_nb)
    );

    assign fin_ready = !out_valid_reg || !out_stall;
    assign in_stall  = !prep_ready;

    // Round to nearest, ties away: bump when twice the remainder reaches the divisor
    always_comb
    begin
        round_up    = {div_rem, 1'b0} >= {1'b0, div_nb};
        qr          = {1'b0, div_quo} + fpa_pkg::qr_t'(round_up);
        div_sat     = fpa_pkg::sat_mag(fpa_pkg::prod_t'(qr), div_side.neg);
        result_next = div_side.is_div ? div_sat.val : div_side.res;
        ov_next     = div_side.is_div ? div_sat.ov  : div_side.ov;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_ready && div_valid)
        begin
            result_reg <= result_next;
            gt_reg     <= div_side.gt;
            lt_reg     <= div_side.lt;
            eq_reg     <= div_side.eq;
            ov_reg     <= ov_next;
            dz_reg     <= div_side.dz;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result      = result_reg;
    assign a_greater   = gt_reg;
    assign a_less      = lt_reg;
    assign a_equal     = eq_reg;
    assign overflow    = ov_reg;
    assign div_by_zero = dz_reg;
    assign cmp_flags   = {gt_reg, lt_reg, eq_reg};

    `FPA_CHECK_NOW(a_cmp_onehot, out_valid, $onehot(cmp_flags))
    `FPA_CHECK_NOW(a_ov_is_bound, out_valid && overflow, (result == fpa_pkg::MAX_VAL) || (result == fpa_pkg::MIN_VAL))
    `FPA_CHECK_NOW(a_zero_by_zero, out_valid && div_by_zero && a_equal, (result == '0) && !overflow)
    `FPA_CHECK_NEXT(a_out_held, out_valid && out_stall, out_valid)

endmodule

`default_nettype wire

// ===== tb/fixed_point_q24_8_alu_tb.sv =====
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_tb;

    localparam int LATENCY = 44;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] a;
        logic [31:0] b;
    } alu_op_t;

    typedef struct packed {
        logic [31:0] res;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        ov;
        logic        dz;
    } alu_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        in_stall_q;
    logic [3:0]  command;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result;
    logic        a_greater;
    logic        a_less;
    logic        a_equal;
    logic        overflow;
    logic        div_by_zero;

    alu_op_t  op_queue[$];
    alu_res_t expected_results[$];
    int       error_count;
    bit       hold_sender;
    int       burst_left;
    int       gap_left;
    int       rx_hold;
    bit       rx_block;

    fixed_point_q24_8_alu dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .a_greater   (a_greater),
        .a_less      (a_less),
        .a_equal     (a_equal),
        .overflow    (overflow),
        .div_by_zero (div_by_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] mag64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint saturate(input longint v, ref bit ov);
        if (v > 64'sd2147483647)
        begin
            ov = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            ov = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic alu_res_t compute_alu(input alu_op_t op);
        alu_res_t    r;
        longint      a;
        longint      b;
        longint      v;
        logic [63:0] m;
        logic [63:0] na;
        logic [63:0] nb;
        bit          neg;
        bit          ov;
        a   = longint'($signed(op.a));
        b   = longint'($signed(op.b));
        v   = 0;
        ov  = 1'b0;
        r   = '0;
        neg = (a < 0) != (b < 0);
        case (op.cmd)
            fpa_pkg::CMD_ADD: v = saturate(a + b, ov);
            fpa_pkg::CMD_SUB: v = saturate(a - b, ov);
            fpa_pkg::CMD_MUL:
            begin
                m = (mag64(a) * mag64(b) + (64'd1 << (fpa_pkg::FRAC_BITS - 1)))
                    >> fpa_pkg::FRAC_BITS;
                v = saturate(neg ? -longint'(m) : longint'(m), ov);
            end
            fpa_pkg::CMD_DIV:
            begin
                if (b == 0)
                begin
                    r.dz = 1'b1;
                    if (a > 0)
                    begin
                        v  = 64'sd2147483647;
                        ov = 1'b1;
                    end
                    else if (a < 0)
                    begin
                        v  = -64'sd2147483648;
                        ov = 1'b1;
                    end
                end
                else
                begin
                    na = mag64(a) << fpa_pkg::FRAC_BITS;
                    nb = mag64(b);
                    m  = (2 * na + nb) / (2 * nb);
                    v  = saturate(neg ? -longint'(m) : longint'(m), ov);
                end
            end
            fpa_pkg::CMD_INC:      v = saturate(a + 1, ov);
            fpa_pkg::CMD_DEC:      v = saturate(a - 1, ov);
            fpa_pkg::CMD_MIN:      v = (a > b) ? b : a;
            fpa_pkg::CMD_MAX:      v = (a < b) ? b : a;
            fpa_pkg::CMD_TO_INT:   v = a / (64'sd1 <<< fpa_pkg::FRAC_BITS);
            fpa_pkg::CMD_FROM_INT: v = saturate(a * (64'sd1 <<< fpa_pkg::FRAC_BITS), ov);
            default:               v = 0;
        endcase
        r.res = v[31:0];
        r.gt  = a > b;
        r.lt  = a < b;
        r.eq  = a == b;
        r.ov  = ov;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 2047)) - 1024);
            1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                           : 32'h80000000 + $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 65535)) - 32768) << $urandom_range(0, 12);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(input logic [3:0] cmd, input logic [31:0] a,
                           input logic [31:0] b);
        alu_op_t op;
        op.cmd = cmd;
        op.a   = a;
        op.b   = b;
        op_queue.push_back(op);
    endtask

    // in_stall as seen at the last rising edge decides acceptance
    always @(posedge clk)
        in_stall_q <= in_stall;

    // Driver: bursts with random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall_q)
            begin
                expected_results.push_back(compute_alu({command, operand_a, operand_b}));
            end
            if (!in_valid || !in_stall_q)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (op_queue.size() > 0 && !hold_sender)
                begin
                    {command, operand_a, operand_b} <= op_queue.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_block)
                out_stall <= 1'b1;
            else if (rx_hold > 0)
            begin
                rx_hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        alu_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected item", result, 32'h0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result !== want.res)
                    report_mismatch("result", result, want.res);
                if (a_greater !== want.gt)
                    report_mismatch("a_greater", 32'(a_greater), 32'(want.gt));
                if (a_less !== want.lt)
                    report_mismatch("a_less", 32'(a_less), 32'(want.lt));
                if (a_equal !== want.eq)
                    report_mismatch("a_equal", 32'(a_equal), 32'(want.eq));
                if (overflow !== want.ov)
                    report_mismatch("overflow", 32'(overflow), 32'(want.ov));
                if (div_by_zero !== want.dz)
                    report_mismatch("div_by_zero", 32'(div_by_zero), 32'(want.dz));
            end
        end
    end

    task automatic wait_drained();
        while (op_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        logic [3:0] cmd;
        logic [31:0] a;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        command     = fpa_pkg::CMD_ADD;
        operand_a   = '0;
        operand_b   = '0;
        error_count = 0;
        burst_left  = 0;
        gap_left    = 0;
        rx_hold     = 0;
        rx_block    = 1'b0;
        hold_sender = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes, rounding ties, divide by zero, unknown commands
        push_op(fpa_pkg::CMD_ADD, 32'h7fffffff, 32'h00000001);
        push_op(fpa_pkg::CMD_SUB, 32'h80000000, 32'h00000001);
        push_op(fpa_pkg::CMD_MUL, 32'h80000000, 32'h80000000);
        push_op(fpa_pkg::CMD_MUL, 32'h00000180, 32'h00000001);
        push_op(fpa_pkg::CMD_MUL, 32'hfffffe80, 32'h00000001);
        push_op(fpa_pkg::CMD_MUL, 32'h7fffffff, 32'hffffffff);
        push_op(fpa_pkg::CMD_DIV, 32'h00000001, 32'h00000200);
        push_op(fpa_pkg::CMD_DIV, 32'hffffffff, 32'h00000200);
        push_op(fpa_pkg::CMD_DIV, 32'h00000100, 32'h00000000);
        push_op(fpa_pkg::CMD_DIV, 32'hffffff00, 32'h00000000);
        push_op(fpa_pkg::CMD_DIV, 32'h00000000, 32'h00000000);
        push_op(fpa_pkg::CMD_DIV, 32'h80000000, 32'h00000001);
        push_op(fpa_pkg::CMD_INC, 32'h7fffffff, 32'h0);
        push_op(fpa_pkg::CMD_DEC, 32'h80000000, 32'h0);
        push_op(fpa_pkg::CMD_MIN, 32'h00000005, 32'h00000005);
        push_op(fpa_pkg::CMD_MAX, 32'h80000000, 32'h7fffffff);
        push_op(fpa_pkg::CMD_TO_INT, 32'hfffffe80, 32'h0);
        push_op(fpa_pkg::CMD_TO_INT, 32'h80000000, 32'hffffffff);
        push_op(fpa_pkg::CMD_FROM_INT, 32'h00800000, 32'h0);
        push_op(fpa_pkg::CMD_FROM_INT, 32'hff7fffff, 32'h0);
        push_op(fpa_pkg::CMD_FROM_INT, 32'h007fffff, 32'h0);
        push_op(4'd10, 32'h00000003, 32'h00000004);
        push_op(4'd15, 32'hffffffff, 32'hffffffff);

        // Sender pauses until every expected result has come
        wait_drained();
        for (n = 0; n < 2000; n++)
        begin
            cmd = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
            a   = rand_operand();
            push_op(cmd, a, ($urandom_range(0, 7) == 0) ? 32'h0 : rand_operand());
            if (n == 700)
            begin
                // long receiver hold-off while the sender keeps offering
                rx_hold = 200;
            end
        end
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
